### rtl/cci_pkg.sv
// ----------------------------------------------------------------------------
// cci_pkg: shared types for the circle intersection pipeline
// Field widths, status codes and the transfer structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

  // Coordinate width, radius width and digit size of the staged multipliers.
  localparam int unsigned COORD_WIDTH  = 32;
  localparam int unsigned RADIUS_WIDTH = COORD_WIDTH - 1;
  localparam int unsigned MUL_DIGIT    = 16;

  // Outcome of one query.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FAR        = 2'd1,
    STATUS_INSIDE     = 2'd2,
    STATUS_COINCIDENT = 2'd3
  } status_e;

  // One query: two circles.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_center_x;
    logic signed [COORD_WIDTH-1:0] first_center_y;
    logic        [RADIUS_WIDTH-1:0] first_radius;
    logic signed [COORD_WIDTH-1:0] second_center_x;
    logic signed [COORD_WIDTH-1:0] second_center_y;
    logic        [RADIUS_WIDTH-1:0] second_radius;
  } item_t;

  // One result: status and both crossing points.
  typedef struct packed {
    status_e                       status;
    logic signed [COORD_WIDTH-1:0] point_a_x;
    logic signed [COORD_WIDTH-1:0] point_a_y;
    logic signed [COORD_WIDTH-1:0] point_b_x;
    logic signed [COORD_WIDTH-1:0] point_b_y;
  } result_t;

endpackage

`default_nettype wire

### rtl/cci_mul.sv
// ----------------------------------------------------------------------------
// cci_mul: staged signed multiplier
// Multiplies magnitudes one digit of the second operand per stage, then
// restores the sign. Side data and a valid bit travel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_mul #(
  parameter int unsigned WA = 66,
  parameter int unsigned WB = 33,
  parameter int unsigned WS = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire logic signed [WA-1:0] a_i,
  input  wire logic signed [WB-1:0] b_i,
  input  wire logic        [WS-1:0] side_i,
  output logic                      valid_o,
  output logic signed [WA+WB-1:0]   p_o,
  output logic        [WS-1:0]      side_o
);

  localparam int unsigned DIG  = cci_pkg::MUL_DIGIT;
  localparam int unsigned NDIG = (WB + DIG - 1) / DIG;
  localparam int unsigned BPW  = NDIG * DIG;
  localparam int unsigned PW   = WA + WB;
  localparam int unsigned PPW  = WA + DIG;

  logic [WA-1:0]  a_abs;
  logic [WB-1:0]  b_abs;
  logic [WA-1:0]  amag_q [NDIG];
  logic [BPW-1:0] bpad_q [NDIG];
  logic [PW-1:0]  acc_q  [NDIG+1];
  logic           neg_q  [NDIG+1];
  logic [WS-1:0]  side_q [NDIG+1];
  logic           valid_q[NDIG+1];
  logic [PW-1:0]  p_q;
  logic [WS-1:0]  side_out_q;
  logic           valid_out_q;

  // Magnitudes of both operands.
  assign a_abs = a_i[WA-1] ? WA'(~a_i + 1'b1) : WA'(a_i);
  assign b_abs = b_i[WB-1] ? WB'(~b_i + 1'b1) : WB'(b_i);

  // Entry stage: split signs from magnitudes.
  always_ff @(posedge clk_i) begin
    amag_q[0] <= a_abs;
    bpad_q[0] <= BPW'(b_abs);
    acc_q[0]  <= '0;
    neg_q[0]  <= a_i[WA-1] ^ b_i[WB-1];
    side_q[0] <= side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
    end
  end

  // One partial product per stage, added in at its digit position.
  for (genvar i = 0; i < NDIG; i++) begin : g_digit
    logic [PPW-1:0] pp;
    assign pp = PPW'(amag_q[i]) * PPW'(bpad_q[i][i*DIG +: DIG]);

    always_ff @(posedge clk_i) begin
      acc_q[i+1]  <= acc_q[i] + (PW'(pp) << (i * DIG));
      neg_q[i+1]  <= neg_q[i];
      side_q[i+1] <= side_q[i];
    end

    if (i + 1 < NDIG) begin : g_pass
      always_ff @(posedge clk_i) begin
        amag_q[i+1] <= amag_q[i];
        bpad_q[i+1] <= bpad_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else begin
        valid_q[i+1] <= valid_q[i];
      end
    end
  end

  // Final stage: restore the sign.
  always_ff @(posedge clk_i) begin
    p_q        <= neg_q[NDIG] ? PW'(~acc_q[NDIG] + 1'b1) : acc_q[NDIG];
    side_out_q <= side_q[NDIG];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else begin
      valid_out_q <= valid_q[NDIG];
    end
  end

  assign p_o     = $signed(p_q);
  assign side_o  = side_out_q;
  assign valid_o = valid_out_q;

endmodule

`default_nettype wire

### rtl/cci_sqrt.sv
// ----------------------------------------------------------------------------
// cci_sqrt: pipelined square root, rounded to nearest
// One root bit per stage by restoring digit recurrence, then a rounding
// stage. Side data and a valid bit travel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_sqrt #(
  parameter int unsigned N  = 64,
  parameter int unsigned WS = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [2*N-1:0]  rad_i,
  input  wire logic [WS-1:0]   side_i,
  output logic                 valid_o,
  output logic [N:0]           root_o,
  output logic [WS-1:0]        side_o
);

  logic [2*N-1:0] rad_q  [N];
  logic [N:0]     rem_q  [N];
  logic [N-1:0]   root_q [N];
  logic [WS-1:0]  side_q [N];
  logic           valid_q[N];
  logic [N:0]     root_out_q;
  logic [WS-1:0]  side_out_q;
  logic           valid_out_q;

  // One recurrence step per stage, taking two radicand bits.
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [2*N-1:0] rad_in;
    logic [N:0]     rem_in;
    logic [N-1:0]   root_in;
    logic [WS-1:0]  side_in;
    logic           valid_in;
    logic [N+1:0]   remx;
    logic [N+1:0]   trial;
    logic           ge;

    if (i == 0) begin : g_first
      assign rad_in   = rad_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rad_in   = rad_q[i-1];
      assign rem_in   = rem_q[i-1];
      assign root_in  = root_q[i-1];
      assign side_in  = side_q[i-1];
      assign valid_in = valid_q[i-1];
    end

    assign remx  = {rem_in[N-1:0], rad_in[2*N-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = remx >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[i]  <= ge ? (N+1)'(remx - trial) : remx[N:0];
      root_q[i] <= {root_in[N-2:0], ge};
      side_q[i] <= side_in;
    end

    if (i + 1 < N) begin : g_shift
      always_ff @(posedge clk_i) begin
        rad_q[i] <= rad_in << 2;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else begin
        valid_q[i] <= valid_in;
      end
    end
  end

  // Round: the remainder exceeds the floor root when the true root is past
  // the half.
  always_ff @(posedge clk_i) begin
    root_out_q <= (rem_q[N-1] > (N+1)'(root_q[N-1])) ?
                  (N+1)'(root_q[N-1]) + (N+1)'(1) : (N+1)'(root_q[N-1]);
    side_out_q <= side_q[N-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_out_q <= 1'b0;
    end else begin
      valid_out_q <= valid_q[N-1];
    end
  end

  assign root_o  = root_out_q;
  assign side_o  = side_out_q;
  assign valid_o = valid_out_q;

endmodule

`default_nettype wire

### rtl/cci_div.sv
// ----------------------------------------------------------------------------
// cci_div: pipelined rounding divider with offset and saturation
// Divides a signed numerator by a positive divisor one quotient bit per
// stage, rounds half away from zero, adds a base and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module cci_div #(
  parameter int unsigned NW = 100,
  parameter int unsigned QB = 34,
  parameter int unsigned W  = 32
) (
  input  wire logic                 clk_i,
  input  wire logic signed [NW-1:0] num_i,
  input  wire logic [NW-QB-1:0]     den_i,
  input  wire logic signed [W-1:0]  base_i,
  output logic signed [W-1:0]       coord_o
);

  localparam int unsigned DNW  = NW - QB;
  localparam int unsigned SUMW = ((W > QB + 2) ? W : QB + 2) + 1;
  localparam logic signed [SUMW-1:0] SAT_MAX = (SUMW'(1) << (W - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] SAT_MIN = ~SAT_MAX;

  logic [NW-1:0]         mag;
  logic [DNW-1:0]        rem_q  [QB+1];
  logic [QB-1:0]         lo_q   [QB];
  logic [QB-1:0]         quo_q  [QB];
  logic [DNW-1:0]        den_q  [QB+1];
  logic signed [W-1:0]   base_q [QB+1];
  logic                  neg_q  [QB+1];
  logic                  up;
  logic [QB:0]           qr;
  logic signed [QB+1:0]  sq_q;
  logic signed [W-1:0]   base_r_q;
  logic signed [SUMW-1:0] sum;
  logic signed [W-1:0]   coord_q;

  assign mag = num_i[NW-1] ? NW'(~num_i + 1'b1) : NW'(num_i);

  // Entry stage: the upper numerator bits are already below the divisor.
  always_ff @(posedge clk_i) begin
    rem_q[0]  <= mag[NW-1:QB];
    lo_q[0]   <= mag[QB-1:0];
    den_q[0]  <= den_i;
    base_q[0] <= base_i;
    neg_q[0]  <= num_i[NW-1];
  end

  // One quotient bit per stage.
  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [QB-1:0] quo_in;
    logic [DNW:0]  remx;
    logic          ge;

    if (i == 0) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = quo_q[i-1];
    end

    assign remx = {rem_q[i], lo_q[i][QB-1]};
    assign ge   = remx >= {1'b0, den_q[i]};

    always_ff @(posedge clk_i) begin
      rem_q[i+1]  <= ge ? DNW'(remx - {1'b0, den_q[i]}) : remx[DNW-1:0];
      quo_q[i]    <= {quo_in[QB-2:0], ge};
      den_q[i+1]  <= den_q[i];
      base_q[i+1] <= base_q[i];
      neg_q[i+1]  <= neg_q[i];
    end

    if (i + 1 < QB) begin : g_shift
      always_ff @(posedge clk_i) begin
        lo_q[i+1] <= lo_q[i] << 1;
      end
    end
  end

  // Round half away from zero, then apply the sign.
  assign up = {rem_q[QB], 1'b0} >= {1'b0, den_q[QB]};
  assign qr = (QB+1)'(quo_q[QB-1]) + (QB+1)'(up);

  always_ff @(posedge clk_i) begin
    sq_q     <= neg_q[QB] ? $signed((QB+2)'(~{1'b0, qr} + 1'b1)) : $signed({1'b0, qr});
    base_r_q <= base_q[QB];
  end

  // Add the base and saturate to the coordinate range.
  assign sum = SUMW'(base_r_q) + SUMW'(sq_q);

  always_ff @(posedge clk_i) begin
    if (sum > SAT_MAX) begin
      coord_q <= W'(SAT_MAX);
    end else if (sum < SAT_MIN) begin
      coord_q <= W'(SAT_MIN);
    end else begin
      coord_q <= W'(sum);
    end
  end

  assign coord_o = coord_q;

endmodule

`default_nettype wire

### rtl/circle_circle_intersection.sv
// ----------------------------------------------------------------------------
// circle_circle_intersection: crossing points of two circles
// Fully pipelined geometry unit on signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
// A query is taken whenever start_i is high; busy_o stays low, so one query
// can be transferred in every clock cycle. Each result appears on result_o
// for a single cycle with done_o high, in query order; the receiver must
// take it then, as there is no way to hold it. The square root of the
// 128-bit chord product and the rounding dividers that follow make up most
// of the pipeline, with short staged multipliers and range checks around
// them.
`default_nettype none

module circle_circle_intersection (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire cci_pkg::item_t  item_i,
  output logic                 busy_o,
  output logic                 done_o,
  output cci_pkg::result_t     result_o
);

  localparam int unsigned W      = cci_pkg::COORD_WIDTH;
  localparam int unsigned KW     = 2 * W + 2;
  localparam int unsigned SW     = 2 * W + 1;
  localparam int unsigned NW     = 3 * W + 4;
  localparam int unsigned QB     = W + 2;
  localparam int unsigned DIVLAT = QB + 3;

  typedef struct packed {
    cci_pkg::status_e     st;
    logic signed [KW-1:0] k;
    logic [2*W:0]         d;
    logic signed [W:0]    dx;
    logic signed [W:0]    dy;
    logic signed [W-1:0]  x0;
    logic signed [W-1:0]  y0;
  } geo_t;

  // Stage 1: centre differences and radius sum and difference.
  logic signed [W:0]   dx_d, dy_d, dx1_q, dy1_q;
  logic signed [W-1:0] rdf_d, rdf1_q, x01_q, y01_q;
  logic [W-1:0]        adx1_q, ady1_q, rs1_q;
  logic [W-2:0]        rd1_q;
  logic                v1_q;

  assign dx_d  = (W+1)'(item_i.second_center_x) - (W+1)'(item_i.first_center_x);
  assign dy_d  = (W+1)'(item_i.second_center_y) - (W+1)'(item_i.first_center_y);
  assign rdf_d = $signed({1'b0, item_i.first_radius}) - $signed({1'b0, item_i.second_radius});

  always_ff @(posedge clk_i) begin
    dx1_q  <= dx_d;
    dy1_q  <= dy_d;
    adx1_q <= dx_d[W] ? W'(~dx_d + 1'b1) : W'(dx_d);
    ady1_q <= dy_d[W] ? W'(~dy_d + 1'b1) : W'(dy_d);
    rs1_q  <= W'(item_i.first_radius) + W'(item_i.second_radius);
    rdf1_q <= rdf_d;
    rd1_q  <= rdf_d[W-1] ? (W-1)'(~rdf_d + 1'b1) : (W-1)'(rdf_d);
    x01_q  <= item_i.first_center_x;
    y01_q  <= item_i.first_center_y;
  end

  // Stage 2: squares and the difference of the squared radii.
  logic [2*W-1:0]      sqx2_q, sqy2_q, sumsq2_q, diffsq2_q;
  logic signed [2*W:0] qd2_q;
  logic signed [W:0]   dx2_q, dy2_q;
  logic signed [W-1:0] x02_q, y02_q;
  logic                v2_q;

  always_ff @(posedge clk_i) begin
    sqx2_q    <= (2*W)'(adx1_q) * (2*W)'(adx1_q);
    sqy2_q    <= (2*W)'(ady1_q) * (2*W)'(ady1_q);
    sumsq2_q  <= (2*W)'(rs1_q) * (2*W)'(rs1_q);
    diffsq2_q <= (2*W)'(rd1_q) * (2*W)'(rd1_q);
    qd2_q     <= (2*W+1)'($signed({1'b0, rs1_q})) * (2*W+1)'(rdf1_q);
    dx2_q     <= dx1_q;
    dy2_q     <= dy1_q;
    x02_q     <= x01_q;
    y02_q     <= y01_q;
  end

  // Stage 3: squared centre distance.
  logic [2*W:0]        d3_q;
  logic [2*W-1:0]      sumsq3_q, diffsq3_q;
  logic signed [2*W:0] qd3_q;
  logic signed [W:0]   dx3_q, dy3_q;
  logic signed [W-1:0] x03_q, y03_q;
  logic                v3_q;

  always_ff @(posedge clk_i) begin
    d3_q      <= (2*W+1)'(sqx2_q) + (2*W+1)'(sqy2_q);
    sumsq3_q  <= sumsq2_q;
    diffsq3_q <= diffsq2_q;
    qd3_q     <= qd2_q;
    dx3_q     <= dx2_q;
    dy3_q     <= dy2_q;
    x03_q     <= x02_q;
    y03_q     <= y02_q;
  end

  // Stage 4: range checks and the chord foot term.
  cci_pkg::status_e     st_d, st4_q;
  logic signed [KW-1:0] k4_q;
  logic [2*W:0]         d4_q;
  logic [2*W-1:0]       sumsq4_q, diffsq4_q;
  logic signed [W:0]    dx4_q, dy4_q;
  logic signed [W-1:0]  x04_q, y04_q;
  logic                 v4_q;

  always_comb begin
    if (d3_q > (2*W+1)'(sumsq3_q)) begin
      st_d = cci_pkg::STATUS_FAR;
    end else if (d3_q < (2*W+1)'(diffsq3_q)) begin
      st_d = cci_pkg::STATUS_INSIDE;
    end else if (d3_q == '0) begin
      st_d = cci_pkg::STATUS_COINCIDENT;
    end else begin
      st_d = cci_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    st4_q     <= st_d;
    k4_q      <= KW'(qd3_q) + $signed({1'b0, d3_q});
    d4_q      <= d3_q;
    sumsq4_q  <= sumsq3_q;
    diffsq4_q <= diffsq3_q;
    dx4_q     <= dx3_q;
    dy4_q     <= dy3_q;
    x04_q     <= x03_q;
    y04_q     <= y03_q;
  end

  // Stage 5: the two factors of the squared chord.
  logic [2*W:0]   fa_d, fb_d;
  logic [2*W-1:0] fa5_q, fb5_q;
  geo_t           geo5_q;
  logic           v5_q;

  assign fa_d = (2*W+1)'(sumsq4_q) - d4_q;
  assign fb_d = d4_q - (2*W+1)'(diffsq4_q);

  always_ff @(posedge clk_i) begin
    fa5_q     <= fa_d[2*W-1:0];
    fb5_q     <= fb_d[2*W-1:0];
    geo5_q.st <= st4_q;
    geo5_q.k  <= k4_q;
    geo5_q.d  <= d4_q;
    geo5_q.dx <= dx4_q;
    geo5_q.dy <= dy4_q;
    geo5_q.x0 <= x04_q;
    geo5_q.y0 <= y04_q;
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Chord product and its rounded square root.
  logic                     vp;
  logic signed [4*W+1:0]    prod_p;
  logic [$bits(geo_t)-1:0]  geop_raw, geos_raw;
  logic                     vs;
  logic [SW-1:0]            root_s;
  geo_t                     geo_s;

  cci_mul #(
    .WA (2*W+1),
    .WB (2*W+1),
    .WS ($bits(geo_t))
  ) u_mul_chord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .a_i     ($signed({1'b0, fa5_q})),
    .b_i     ($signed({1'b0, fb5_q})),
    .side_i  (geo5_q),
    .valid_o (vp),
    .p_o     (prod_p),
    .side_o  (geop_raw)
  );

  cci_sqrt #(
    .N  (2*W),
    .WS ($bits(geo_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp),
    .rad_i   (prod_p[4*W-1:0]),
    .side_i  (geop_raw),
    .valid_o (vs),
    .root_o  (root_s),
    .side_o  (geos_raw)
  );

  assign geo_s = geos_raw;

  // Four products of the offsets with the foot term and the half chord.
  localparam int unsigned PW = KW + W + 1;

  logic                     vm0, vm1, vm2, vm3;
  logic signed [PW-1:0]     dxk, dyk, dys, dxs;
  logic [$bits(cci_pkg::status_e)-1:0] st_m;
  logic [2*W:0]             d_m;
  logic [W-1:0]             x0_m, y0_m;

  cci_mul #(.WA (KW), .WB (W+1), .WS ($bits(cci_pkg::status_e))) u_mul_dxk (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (vs),
    .a_i (geo_s.k), .b_i (geo_s.dx), .side_i (geo_s.st),
    .valid_o (vm0), .p_o (dxk), .side_o (st_m)
  );

  cci_mul #(.WA (KW), .WB (W+1), .WS (2*W+1)) u_mul_dyk (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (vs),
    .a_i (geo_s.k), .b_i (geo_s.dy), .side_i (geo_s.d),
    .valid_o (vm1), .p_o (dyk), .side_o (d_m)
  );

  cci_mul #(.WA (SW+1), .WB (W+1), .WS (W)) u_mul_dys (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (vs),
    .a_i ($signed({1'b0, root_s})), .b_i (geo_s.dy), .side_i (geo_s.x0),
    .valid_o (vm2), .p_o (dys), .side_o (x0_m)
  );

  cci_mul #(.WA (SW+1), .WB (W+1), .WS (W)) u_mul_dxs (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (vs),
    .a_i ($signed({1'b0, root_s})), .b_i (geo_s.dx), .side_i (geo_s.y0),
    .valid_o (vm3), .p_o (dxs), .side_o (y0_m)
  );

  // Stage 6: numerators of the four coordinates and the common divisor.
  logic signed [NW-1:0] nax6_q, nay6_q, nbx6_q, nby6_q;
  logic [2*W+1:0]       den6_q;
  logic signed [W-1:0]  x06_q, y06_q;
  cci_pkg::status_e     st6_q;
  logic                 v6_q;

  always_ff @(posedge clk_i) begin
    nax6_q <= NW'(dxk) - NW'(dys);
    nay6_q <= NW'(dyk) + NW'(dxs);
    nbx6_q <= NW'(dxk) + NW'(dys);
    nby6_q <= NW'(dyk) - NW'(dxs);
    den6_q <= {d_m, 1'b0};
    x06_q  <= $signed(x0_m);
    y06_q  <= $signed(y0_m);
    st6_q  <= cci_pkg::status_e'(st_m);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= vm0 && vm1 && vm2 && vm3;
    end
  end

  // Rounding dividers, one for each coordinate.
  logic signed [W-1:0] pax, pay, pbx, pby;

  cci_div #(.NW (NW), .QB (QB), .W (W)) u_div_ax (
    .clk_i (clk_i), .num_i (nax6_q), .den_i (den6_q), .base_i (x06_q), .coord_o (pax)
  );
  cci_div #(.NW (NW), .QB (QB), .W (W)) u_div_ay (
    .clk_i (clk_i), .num_i (nay6_q), .den_i (den6_q), .base_i (y06_q), .coord_o (pay)
  );
  cci_div #(.NW (NW), .QB (QB), .W (W)) u_div_bx (
    .clk_i (clk_i), .num_i (nbx6_q), .den_i (den6_q), .base_i (x06_q), .coord_o (pbx)
  );
  cci_div #(.NW (NW), .QB (QB), .W (W)) u_div_by (
    .clk_i (clk_i), .num_i (nby6_q), .den_i (den6_q), .base_i (y06_q), .coord_o (pby)
  );

  // Status and valid follow the dividers down a delay line.
  cci_pkg::status_e ds_q [DIVLAT];
  logic             dv_q [DIVLAT];

  always_ff @(posedge clk_i) begin
    ds_q[0] <= st6_q;
    for (int j = 1; j < DIVLAT; j++) begin
      ds_q[j] <= ds_q[j-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DIVLAT; j++) begin
        dv_q[j] <= 1'b0;
      end
    end else begin
      dv_q[0] <= v6_q;
      for (int j = 1; j < DIVLAT; j++) begin
        dv_q[j] <= dv_q[j-1];
      end
    end
  end

  // Output register: points are cleared unless the circles cross.
  cci_pkg::result_t result_q;
  logic             done_q;
  logic             ok;

  assign ok = ds_q[DIVLAT-1] == cci_pkg::STATUS_OK;

  always_ff @(posedge clk_i) begin
    result_q.status    <= ds_q[DIVLAT-1];
    result_q.point_a_x <= ok ? pax : '0;
    result_q.point_a_y <= ok ? pay : '0;
    result_q.point_b_x <= ok ? pbx : '0;
    result_q.point_b_y <= ok ? pby : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_q[DIVLAT-1];
    end
  end

  assign busy_o   = 1'b0;
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for circle_circle_intersection
// Sends two-circle queries (directed corners, well-formed crossing circles and
// raw noise) with random gaps, predicts every result in 128-bit integers and
// compares each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 140;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  cci_pkg::item_t   item_i = '0;
  logic             busy_o;
  logic             done_o;
  cci_pkg::result_t result_o;

  cci_pkg::result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned query_count = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};

  circle_circle_intersection dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Free-running clock, 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Widening helper to the 128-bit working width.
  function automatic logic [127:0] wide_coord(logic [31:0] v);
    return {{96{v[31]}}, v};
  endfunction

  // Square root of a 128-bit value, rounded to nearest.
  function automatic logic [127:0] chord_root(logic [127:0] p);
    logic [127:0] res;
    logic [127:0] rem;
    logic [127:0] one;
    logic [127:0] t;
    res = '0;
    rem = p;
    one = 128'h1 << 126;
    while (one > rem && one != 0) one = one >> 2;
    while (one != 0) begin
      t = res + one;
      if (rem >= t) begin
        rem = rem - t;
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    if (rem > res) res = res + 1;
    return res;
  endfunction

  // Signed quotient by a positive divisor, ties rounded away from zero.
  function automatic logic [127:0] div_nearest(logic [127:0] num, logic [127:0] den);
    logic         neg;
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] rem;
    neg = num[127];
    mag = neg ? -num : num;
    q   = mag / den;
    rem = mag % den;
    if ((rem << 1) >= den) q = q + 1;
    return neg ? -q : q;
  endfunction

  // Clamp to the signed 32-bit coordinate range.
  function automatic logic [31:0] clamp_coord(logic [127:0] v);
    if ($signed(v) > $signed(128'sd2147483647)) return 32'h7fff_ffff;
    if ($signed(v) < -$signed(128'sd2147483648)) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Expected crossing points for one query.
  function automatic cci_pkg::result_t crossing_points(cci_pkg::item_t q);
    cci_pkg::result_t r;
    logic [127:0] x0, y0, r0, x1, y1, r1;
    logic [127:0] dx, dy, d2, rs, rd, sumsq, diffsq, k, p, s, den;
    logic [127:0] akx, aky, bsx, bsy;
    x0 = wide_coord(q.first_center_x);
    y0 = wide_coord(q.first_center_y);
    x1 = wide_coord(q.second_center_x);
    y1 = wide_coord(q.second_center_y);
    r0 = {97'b0, q.first_radius};
    r1 = {97'b0, q.second_radius};
    dx = x1 - x0;
    dy = y1 - y0;
    d2 = dx * dx + dy * dy;
    rs = r0 + r1;
    rd = (r0 >= r1) ? r0 - r1 : r1 - r0;
    sumsq  = rs * rs;
    diffsq = rd * rd;
    r = '0;
    if (d2 > sumsq) begin
      r.status = cci_pkg::STATUS_FAR;
    end else if (d2 < diffsq) begin
      r.status = cci_pkg::STATUS_INSIDE;
    end else if (d2 == 0) begin
      r.status = cci_pkg::STATUS_COINCIDENT;
    end else begin
      r.status = cci_pkg::STATUS_OK;
      k   = r0 * r0 - r1 * r1 + d2;
      p   = (sumsq - d2) * (d2 - diffsq);
      s   = chord_root(p);
      den = d2 << 1;
      akx = dx * k;
      aky = dy * k;
      bsx = dy * s;
      bsy = dx * s;
      r.point_a_x = clamp_coord(x0 + div_nearest(akx - bsx, den));
      r.point_a_y = clamp_coord(y0 + div_nearest(aky + bsy, den));
      r.point_b_x = clamp_coord(x0 + div_nearest(akx + bsx, den));
      r.point_b_y = clamp_coord(y0 + div_nearest(aky - bsy, den));
    end
    return r;
  endfunction

  // Record each transfer and check each strobed result against the oldest one.
  always @(posedge clk_i) begin
    cci_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d", result_o.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        status_seen[want.status]++;
        if (result_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_o.status);
          error_count++;
        end
        if (result_o.point_a_x !== want.point_a_x) begin
          $error("point_a_x: expected %h, got %h", want.point_a_x, result_o.point_a_x);
          error_count++;
        end
        if (result_o.point_a_y !== want.point_a_y) begin
          $error("point_a_y: expected %h, got %h", want.point_a_y, result_o.point_a_y);
          error_count++;
        end
        if (result_o.point_b_x !== want.point_b_x) begin
          $error("point_b_x: expected %h, got %h", want.point_b_x, result_o.point_b_x);
          error_count++;
        end
        if (result_o.point_b_y !== want.point_b_y) begin
          $error("point_b_y: expected %h, got %h", want.point_b_y, result_o.point_b_y);
          error_count++;
        end
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      pending_results.push_back(crossing_points(item_i));
      query_count++;
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one query; called and left at a falling edge, start stays high.
  task automatic send_query(cci_pkg::item_t q, bit may_idle);
    while (may_idle && $urandom_range(0, 99) < 27) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic cci_pkg::item_t make_query(int x0, int y0, int r0, int x1, int y1,
                                                int r1);
    cci_pkg::item_t q;
    q.first_center_x  = x0;
    q.first_center_y  = y0;
    q.first_radius    = r0[30:0];
    q.second_center_x = x1;
    q.second_center_y = y1;
    q.second_radius   = r1[30:0];
    return q;
  endfunction

  // Two crossing circles with random content near a random origin.
  function automatic cci_pkg::item_t crossing_query(bit huge);
    int  x0, y0, dx, dy, r0, lo, hi, span;
    real d;
    span = huge ? 28 : $urandom_range(0, 22);
    x0 = huge ? $urandom : $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    y0 = huge ? $urandom : $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    dx = $signed($urandom_range(0, (1 << span) - 1)) - ((1 << span) >> 1);
    dy = $signed($urandom_range(0, (1 << span) - 1)) - ((1 << span) >> 1);
    if (dx == 0 && dy == 0) dx = 1;
    d  = $sqrt(real'(dx) * dx + real'(dy) * dy);
    r0 = $urandom_range(0, (1 << (span + 1)));
    lo = int'($ceil(d > r0 ? d - r0 : r0 - d));
    hi = int'($floor(d + r0));
    if (lo > hi) lo = hi;
    return make_query(x0, y0, r0, x0 + dx, y0 + dy, $urandom_range(lo, hi));
  endfunction

  // Field extremes and saturation corners.
  task automatic test_field_extremes();
    send_query(make_query(0, 0, 0, 0, 0, 0), 1'b0);
    send_query(make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff), 1'b0);
    send_query(make_query(32'h8000_0000, 32'h8000_0000, 0,
                          32'h7fff_ffff, 32'h7fff_ffff, 0), 1'b0);
    send_query(make_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1'b0);
    send_query(make_query(32'h7fff_0000, 0, 32'h4000_0000,
                          32'h7fff_0000, 32'h0001_0000, 32'h4000_0000), 1'b0);
    send_query(make_query(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                          32'h8000_0001, 32'h8000_0000, 32'h7fff_ffff), 1'b0);
    send_query(make_query(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff), 1'b0);
    send_query(make_query(0, 0, 32'h7fff_ffff, 1, 1, 32'h7fff_ffff), 1'b0);
  endtask

  // Far apart, one inside the other, coincident, touching and crossing circles.
  task automatic test_special_cases();
    send_query(make_query(0, 0, 32'h0001_0000, 32'h0010_0000, 0, 32'h0001_0000), 1'b0);
    send_query(make_query(0, 0, 32'h0010_0000, 32'h0001_0000, 0, 32'h0001_0000), 1'b0);
    send_query(make_query(0, 0, 32'h0001_0000, 0, 32'h0001_0000, 32'h0010_0000), 1'b0);
    send_query(make_query(32'h1234_5678, -5, 32'h0003_0000,
                          32'h1234_5678, -5, 32'h0003_0000), 1'b0);
    send_query(make_query(-7, 9, 0, -7, 9, 0), 1'b0);
    send_query(make_query(0, 0, 5, 0, 0, 6), 1'b0);
    send_query(make_query(0, 0, 32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000), 1'b0);
    send_query(make_query(0, 0, 32'h0003_0000, 32'h0001_0000, 0, 32'h0002_0000), 1'b0);
    send_query(make_query(10, 10, 3, 10, 16, 3), 1'b0);
    send_query(make_query(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                          32'h0001_0000), 1'b0);
    send_query(make_query(0, 0, 1, 0, 1, 1), 1'b0);
    send_query(make_query(0, 0, 1, 1, 0, 0), 1'b0);
  endtask

  // Sender holds off until the pipeline is empty.
  task automatic test_drain_pause();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    send_query(crossing_query(1'b0), 1'b0);
  endtask

  // Mostly crossing circles, some concentric ones, the rest raw noise, with random gaps when may_idle is set.
  task automatic test_random_queries(int unsigned count, bit may_idle);
    cci_pkg::item_t q;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) q = crossing_query(1'b0);
      else if (pick < 75) q = crossing_query(1'b1);
      else if (pick < 80) begin
        q = crossing_query(1'b0);
        q.second_center_x = q.first_center_x;
        q.second_center_y = q.first_center_y;
        if (pick[0]) q.second_radius = q.first_radius;
      end else begin
        q = $bits(cci_pkg::item_t)'({$urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom});
      end
      send_query(q, may_idle);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_field_extremes();
    test_special_cases();
    test_random_queries(400, 1'b1);
    test_drain_pause();
    test_random_queries(300, 1'b0);
    test_random_queries(450, 1'b1);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d queries: %0d crossing, %0d far apart, %0d nested, %0d coincident.",
             query_count, status_seen[cci_pkg::STATUS_OK], status_seen[cci_pkg::STATUS_FAR],
             status_seen[cci_pkg::STATUS_INSIDE], status_seen[cci_pkg::STATUS_COINCIDENT]);
    $display("Included field extremes, saturation, touching circles and a drained pause.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/cci_pkg.sv
rtl/cci_mul.sv
rtl/cci_sqrt.sv
rtl/cci_div.sv
rtl/circle_circle_intersection.sv
tb/testbench.sv
